// ===== hdl/tosf_pkg.sv =====
package tosf_pkg;

  localparam int OUT_W = 16;
  localparam int IN_UW = 3;

  typedef enum logic [1:0] {
    FN_CLEAR = 2'd0,
    FN_ADD   = 2'd1,
    FN_TEST  = 2'd2
  } func_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DEC,
    ST_PREP,
    ST_T_RD,
    ST_T_S1,
    ST_T_S2,
    ST_T_S3,
    ST_L_RD,
    ST_L_S1,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic load_in;
    logic cnt_clr;
    logic wr_en;
    logic set_ovf;
    logic set_rej;
    logic ld_prep;
    logic rd_en;
    logic rd_inner;
    logic ld_s1;
    logic ld_s2;
    logic i_clr;
    logic i_inc;
    logic k_clr;
    logic k_inc;
    logic res_ld;
  } cmd_t;

  typedef struct packed {
    func_t func;
    logic  sh_empty;
    logic  cnt_zero;
    logic  cnt_full;
    logic  i_last;
    logic  k_last;
    logic  skip;
    logic  dom_in;
    logic  glyph_pre;
    logic  line_hit;
  } sts_t;

endpackage

// ===== hdl/text_overlap_shape_filter.sv =====
// Text overlap shape filter.
// The input stream carries one command item per transfer: clear the text table,
// add a text box, or test a detected shape box against all stored text boxes.
// The command and the circle flag travel in in_tuser, the box fields in in_tdata.
// Every accepted item yields exactly one result item on the output stream with
// the reject flag, the overflow flag and the number of stored text boxes.
// Clear, add and unused items, and tests of an empty shape or against an empty
// table, go from the decode state straight to the result state; after the result
// is loaded, the controller returns to idle and accepts the next item there.
// Any other test passes each stored box through the read, S1, S2 and S3 states,
// plus a read and a check state per table entry for each one-character box that
// passes the glyph checks, and ends early at the first hit, since the controller
// steps through the box table one entry per read of its single memory port.
// One item is processed at a time; the next item is accepted once the current
// result sits in the output register, even if the receiver has not taken it.
// When the receiver stalls, the result holds and the block waits with the next
// result until the output register is free.
// Synchronous reset empties the table and drops any pending result; table
// contents themselves are not cleared.
module text_overlap_shape_filter #(
  parameter int MAX_TEXT_BOXES = 64,
  parameter int COORD_BITS = 12,
  localparam int IN_W = ((4 * COORD_BITS + 8 + 7) / 8) * 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  // pos_x, pos_y, box_width, box_height, visible_chars.
  input  logic [IN_W-1:0]            in_tdata,
  // func, is_circle.
  input  logic [tosf_pkg::IN_UW-1:0] in_tuser,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  // reject, overflow, region_count.
  output logic [tosf_pkg::OUT_W-1:0] out_tdata
);

  tosf_pkg::cmd_t cmd;
  tosf_pkg::sts_t sts;

  tosf_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  tosf_dp #(
    .MAX_TEXT_BOXES (MAX_TEXT_BOXES),
    .COORD_BITS     (COORD_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cmd       (cmd),
    .sts       (sts),
    .out_tdata (out_tdata)
  );

endmodule

// ===== hdl/tosf_ctrl.sv =====
module tosf_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  output logic           out_tvalid,
  input  logic           out_tready,
  input  tosf_pkg::sts_t sts,
  output tosf_pkg::cmd_t cmd
);

  tosf_pkg::state_t state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tosf_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    in_tready = 1'b0;
    unique case (state_r)
      tosf_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load_in = 1'b1;
          state_nxt   = tosf_pkg::ST_DEC;
        end
      end
      tosf_pkg::ST_DEC: begin
        state_nxt = tosf_pkg::ST_FIN;
        unique case (sts.func)
          tosf_pkg::FN_CLEAR: cmd.cnt_clr = 1'b1;
          tosf_pkg::FN_ADD: begin
            if (!sts.sh_empty) begin
              if (sts.cnt_full) begin
                cmd.set_ovf = 1'b1;
              end else begin
                cmd.wr_en = 1'b1;
              end
            end
          end
          tosf_pkg::FN_TEST: begin
            if (!sts.sh_empty && !sts.cnt_zero) begin
              cmd.i_clr = 1'b1;
              state_nxt = tosf_pkg::ST_PREP;
            end
          end
          default: state_nxt = tosf_pkg::ST_FIN;
        endcase
      end
      tosf_pkg::ST_PREP: begin
        cmd.ld_prep = 1'b1;
        state_nxt   = tosf_pkg::ST_T_RD;
      end
      tosf_pkg::ST_T_RD: begin
        cmd.rd_en = 1'b1;
        state_nxt = tosf_pkg::ST_T_S1;
      end
      tosf_pkg::ST_T_S1: begin
        cmd.ld_s1 = 1'b1;
        state_nxt = tosf_pkg::ST_T_S2;
      end
      tosf_pkg::ST_T_S2: begin
        cmd.ld_s2 = 1'b1;
        state_nxt = tosf_pkg::ST_T_S3;
      end
      tosf_pkg::ST_T_S3: begin
        if (!sts.skip && sts.dom_in) begin
          cmd.set_rej = 1'b1;
          state_nxt   = tosf_pkg::ST_FIN;
        end else if (!sts.skip && sts.glyph_pre) begin
          cmd.k_clr = 1'b1;
          state_nxt = tosf_pkg::ST_L_RD;
        end else if (sts.i_last) begin
          state_nxt = tosf_pkg::ST_FIN;
        end else begin
          cmd.i_inc = 1'b1;
          state_nxt = tosf_pkg::ST_T_RD;
        end
      end
      tosf_pkg::ST_L_RD: begin
        cmd.rd_en    = 1'b1;
        cmd.rd_inner = 1'b1;
        state_nxt    = tosf_pkg::ST_L_S1;
      end
      tosf_pkg::ST_L_S1: begin
        if (sts.line_hit) begin
          cmd.set_rej = 1'b1;
          state_nxt   = tosf_pkg::ST_FIN;
        end else if (!sts.k_last) begin
          cmd.k_inc = 1'b1;
          state_nxt = tosf_pkg::ST_L_RD;
        end else if (sts.i_last) begin
          state_nxt = tosf_pkg::ST_FIN;
        end else begin
          cmd.i_inc = 1'b1;
          state_nxt = tosf_pkg::ST_T_RD;
        end
      end
      tosf_pkg::ST_FIN: begin
        if (!out_valid_r || out_tready) begin
          cmd.res_ld = 1'b1;
          state_nxt  = tosf_pkg::ST_IDLE;
        end
      end
      default: state_nxt = tosf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.res_ld) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_tvalid = out_valid_r;

endmodule

// ===== hdl/tosf_dp.sv =====
module tosf_dp #(
  parameter int MAX_TEXT_BOXES = 64,
  parameter int COORD_BITS = 12,
  localparam int IN_W = ((4 * COORD_BITS + 8 + 7) / 8) * 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [IN_W-1:0]            in_tdata,
  input  logic [tosf_pkg::IN_UW-1:0] in_tuser,
  input  tosf_pkg::cmd_t             cmd,
  output tosf_pkg::sts_t             sts,
  output logic [tosf_pkg::OUT_W-1:0] out_tdata
);

  localparam int C  = COORD_BITS;
  localparam int AW = (MAX_TEXT_BOXES > 1) ? $clog2(MAX_TEXT_BOXES) : 1;
  localparam int CW = $clog2(MAX_TEXT_BOXES + 1);
  localparam int EW = 4 * C + 8;
  localparam int SW = C + 3;
  localparam int PW = 2 * C + 8;
  localparam int DW = 2 * C + 14;
  localparam int LW = C + 8;

  logic [1:0]   fn_r;
  logic [C-1:0] sx_r, sy_r, sw_r, sh_r;
  logic         circ_r;
  logic [7:0]   sch_r;

  logic [CW-1:0] cnt_r;
  logic [AW-1:0] i_r, k_r;
  logic          rej_r, ovf_r;

  logic [EW-1:0] mem [MAX_TEXT_BOXES];
  logic [EW-1:0] rdata_r;

  logic [C-1:0] ox, oy, ow, oh;
  logic [7:0]   och;

  logic [C-1:0]   rx_r, ry_r, rw_r, rh_r;
  logic [7:0]     rch_r;
  logic signed [SW-1:0] iw_r, ih_r, dx_r, dy_r;
  logic [2*C-1:0] ia_r, ta_r, sa_r, mm_r;
  logic signed [2*SW-1:0] dx2_r, dy2_r;
  logic [tosf_pkg::OUT_W-1:0] out_r;

  logic signed [SW-1:0] sx_s, sy_s, sw_s, sh_s, ox_s, oy_s, ow_s, oh_s;
  logic signed [SW-1:0] rx_s, ry_s, rw_s, rh_s;
  logic signed [SW-1:0] e0, e1, b0, iw_c, ih_c, dx_c, dy_c;
  logic signed [SW-1:0] ov, g1, g2, gm;
  logic [C-1:0]  m_c, minh, maxh;
  logic [PW-1:0] ia_p, sa_p, ta_p, ia100, sa100;
  logic [DW-1:0] d2, mm16;
  logic          dom, ins, gpre, ov_ok, gap_ok, kskip;
  logic [CW+6:0] cnt_ext;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      fn_r   <= in_tuser[1:0];
      circ_r <= in_tuser[2];
      sx_r   <= in_tdata[C-1:0];
      sy_r   <= in_tdata[2*C-1:C];
      sw_r   <= in_tdata[3*C-1:2*C];
      sh_r   <= in_tdata[4*C-1:3*C];
      sch_r  <= in_tdata[4*C+7:4*C];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      rej_r <= 1'b0;
      ovf_r <= 1'b0;
    end else begin
      if (cmd.cnt_clr) begin
        cnt_r <= '0;
      end else if (cmd.wr_en) begin
        cnt_r <= cnt_r + CW'(1);
      end
      if (cmd.load_in) begin
        rej_r <= 1'b0;
        ovf_r <= 1'b0;
      end else begin
        if (cmd.set_rej) rej_r <= 1'b1;
        if (cmd.set_ovf) ovf_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.i_clr) begin
      i_r <= '0;
    end else if (cmd.i_inc) begin
      i_r <= i_r + AW'(1);
    end
    if (cmd.k_clr) begin
      k_r <= '0;
    end else if (cmd.k_inc) begin
      k_r <= k_r + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[cnt_r[AW-1:0]] <= {sch_r, sh_r, sw_r, sy_r, sx_r};
    end
    if (cmd.rd_en) begin
      rdata_r <= mem[cmd.rd_inner ? k_r : i_r];
    end
  end

  assign ox  = rdata_r[C-1:0];
  assign oy  = rdata_r[2*C-1:C];
  assign ow  = rdata_r[3*C-1:2*C];
  assign oh  = rdata_r[4*C-1:3*C];
  assign och = rdata_r[4*C+7:4*C];

  always_comb begin
    sx_s = SW'(sx_r);
    sy_s = SW'(sy_r);
    sw_s = SW'(sw_r);
    sh_s = SW'(sh_r);
    ox_s = SW'(ox);
    oy_s = SW'(oy);
    ow_s = SW'(ow);
    oh_s = SW'(oh);
    rx_s = SW'(rx_r);
    ry_s = SW'(ry_r);
    rw_s = SW'(rw_r);
    rh_s = SW'(rh_r);

    e0   = sx_s + sw_s;
    e1   = ox_s + ow_s;
    b0   = (sx_s > ox_s) ? sx_s : ox_s;
    iw_c = ((e0 < e1) ? e0 : e1) - b0;
    e0   = sy_s + sh_s;
    e1   = oy_s + oh_s;
    b0   = (sy_s > oy_s) ? sy_s : oy_s;
    ih_c = ((e0 < e1) ? e0 : e1) - b0;
    dx_c = (sx_s + sx_s + sw_s) - (ox_s + ox_s + ow_s);
    dy_c = (sy_s + sy_s + sh_s) - (oy_s + oy_s + oh_s);
    m_c  = (sw_r > sh_r) ? sw_r : sh_r;

    e0   = ry_s + rh_s;
    e1   = oy_s + oh_s;
    b0   = (ry_s > oy_s) ? ry_s : oy_s;
    ov   = ((e0 < e1) ? e0 : e1) - b0;
    minh = (rh_r < oh) ? rh_r : oh;
    maxh = (rh_r > oh) ? rh_r : oh;
    g1   = ox_s - (rx_s + rw_s);
    g2   = rx_s - (ox_s + ow_s);
    gm   = (g1 > g2) ? g1 : g2;
    ov_ok  = (ov > 0) && (LW'(ov[C:0]) * LW'(100) > LW'(minh) * LW'(35));
    gap_ok = (gm <= 0) || (LW'(gm[C:0]) * LW'(2) < LW'(maxh) * LW'(3));
    kskip  = (k_r == i_r) || (och < 8'd2);
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_prep) begin
      sa_r <= sw_r * sh_r;
      mm_r <= m_c * m_c;
    end
    if (cmd.ld_s1) begin
      iw_r  <= iw_c;
      ih_r  <= ih_c;
      dx_r  <= dx_c;
      dy_r  <= dy_c;
      rx_r  <= ox;
      ry_r  <= oy;
      rw_r  <= ow;
      rh_r  <= oh;
      rch_r <= och;
    end
    if (cmd.ld_s2) begin
      ia_r  <= iw_r[C-1:0] * ih_r[C-1:0];
      ta_r  <= rw_r * rh_r;
      dx2_r <= dx_r * dx_r;
      dy2_r <= dy_r * dy_r;
    end
  end

  always_comb begin
    ia_p  = PW'(ia_r);
    sa_p  = PW'(sa_r);
    ta_p  = PW'(ta_r);
    ia100 = ia_p * PW'(100);
    sa100 = sa_p * PW'(100);
    d2    = DW'(dx2_r[2*SW-2:0]) + DW'(dy2_r[2*SW-2:0]);
    mm16  = DW'(mm_r) << 4;
    dom   = (ia100 > sa_p * PW'(75)) && (sa100 < ta_p * PW'(115));
    ins   = (ia100 > ta_p * PW'(85)) && (sa100 < ta_p * PW'(130));
    gpre  = circ_r && (rch_r == 8'd1)
            && (ia100 > sa_p * PW'(55)) && (ia100 > ta_p * PW'(55))
            && (sa100 > ta_p * PW'(60)) && (sa100 < ta_p * PW'(160))
            && (d2 * DW'(100) < mm16);
  end

  always_comb begin
    sts.func      = tosf_pkg::func_t'(fn_r);
    sts.sh_empty  = (sw_r == '0) || (sh_r == '0);
    sts.cnt_zero  = (cnt_r == '0);
    sts.cnt_full  = (cnt_r == CW'(MAX_TEXT_BOXES));
    sts.i_last    = ((CW'(i_r) + CW'(1)) == cnt_r);
    sts.k_last    = ((CW'(k_r) + CW'(1)) == cnt_r);
    sts.skip      = (iw_r <= 0) || (ih_r <= 0);
    sts.dom_in    = dom || ins;
    sts.glyph_pre = gpre;
    sts.line_hit  = !kskip && ov_ok && gap_ok;
  end

  assign cnt_ext = {7'd0, cnt_r};

  always_ff @(posedge clk) begin
    if (cmd.res_ld) begin
      out_r <= {7'd0, cnt_ext[6:0], ovf_r, rej_r};
    end
  end

  assign out_tdata = out_r;

endmodule
